@@ sv/sprite_skip_literal_rle_encoder_assert.svh @@
// assertion macros shared by the encoder rtl
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef SPRITE_SKIP_LITERAL_RLE_ENCODER_ASSERT_SVH
`define SPRITE_SKIP_LITERAL_RLE_ENCODER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SSLRE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sslre assertion failed");
`define SSLRE_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("sslre assertion failed");
`else
`define SSLRE_ASSERT(label, clk, rst_n, prop)
`define SSLRE_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ sv/sslre_pkg.sv @@
// types and constants of the skip/literal run-length encoder
// used by every module of the block but the ram; no dependencies
package sslre_pkg;

    localparam int LIT_AW     = 8;
    localparam int RAM_AW     = LIT_AW + 1;
    localparam int RAM_DEPTH  = 1 << RAM_AW;
    localparam int CMD_DEPTH  = 2;
    localparam int CMD_AW     = $clog2(CMD_DEPTH);

    localparam logic [3:0] FULL_BYTES = 4'd8;
    localparam logic [3:0] HALF_BYTES = 4'd4;

    typedef struct packed {
        logic [7:0] pixel;
        logic       last_pixel;
    } t_pixel_in;

    typedef struct packed {
        logic [63:0] packed_bytes;
        logic [3:0]  valid_bytes;
        logic        end_of_picture;
    } t_word_out;

    // one record for the back end: counts, literal bank, picture end
    typedef struct packed {
        logic [7:0]        skip;
        logic [LIT_AW-1:0] lit;
        logic              bank;
        logic              eop;
    } t_cmd;

    typedef struct packed {
        logic vld;
        logic bank;
    } t_bank_free;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SKIP,
        BK_COUNT,
        BK_DATA,
        BK_PAD
    } t_back_state;

endpackage

@@ sv/sslre_ram.sv @@
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module sslre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/sslre_front.sv @@
// front end: takes pixels, counts runs, stores literals, issues records
// depends on sslre_pkg and the assertion header
`include "sprite_skip_literal_rle_encoder_assert.svh"

module sslre_front #(
    parameter int MAX_RUN = 255
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  sslre_pkg::t_pixel_in        i_in_data,
    input  logic                        i_fifo_full,
    output logic                        o_push,
    output sslre_pkg::t_cmd             o_push_cmd,
    output logic                        o_wr_en,
    output logic [sslre_pkg::RAM_AW-1:0] o_wr_addr,
    output logic [7:0]                  o_wr_data,
    input  sslre_pkg::t_bank_free       i_free
);

    localparam logic [7:0] MaxRun = 8'(MAX_RUN);

    logic                          r_lit_phase, n_lit_phase;
    logic [7:0]                    r_skip, n_skip;
    logic [sslre_pkg::LIT_AW-1:0]  r_lit, n_lit;
    logic                          r_bank, n_bank;
    logic [1:0]                    r_busy, n_busy;
    logic                          r_pend, n_pend;
    sslre_pkg::t_cmd               r_pend_cmd, n_pend_cmd;

    logic                          accept;
    logic [sslre_pkg::LIT_AW-1:0]  lit_new;
    sslre_pkg::t_cmd               cmd1, cmd2;
    logic                          cmd1_vld, cmd2_vld;

    assign o_in_stall = r_pend || i_fifo_full || r_busy[r_bank];
    assign accept     = i_in_valid && !o_in_stall;
    assign lit_new    = r_lit + 8'd1;

    assign o_wr_en   = accept && (i_in_data.pixel != 8'd0);
    assign o_wr_addr = {r_bank, r_lit};
    assign o_wr_data = i_in_data.pixel;

    // run bookkeeping and record generation
    always_comb begin
        n_lit_phase = r_lit_phase;
        n_skip      = r_skip;
        n_lit       = r_lit;
        n_bank      = r_bank;
        cmd1        = '0;
        cmd2        = '0;
        cmd1_vld    = 1'b0;
        cmd2_vld    = 1'b0;
        if (accept) begin
            if (i_in_data.pixel == 8'd0) begin
                if (r_lit_phase || (r_skip >= MaxRun)) begin
                    cmd1.skip = r_skip;
                    cmd1.lit  = r_lit;
                    cmd1.bank = r_bank;
                    cmd1_vld  = 1'b1;
                    if (r_lit != '0) begin
                        n_bank = ~r_bank;
                    end
                    n_lit       = '0;
                    n_lit_phase = 1'b0;
                    n_skip      = 8'd1;
                end else begin
                    n_skip = r_skip + 8'd1;
                end
                if (i_in_data.last_pixel) begin
                    // pending skip run closes the picture
                    if (cmd1_vld) begin
                        cmd2.skip = n_skip;
                        cmd2.bank = n_bank;
                        cmd2.eop  = 1'b1;
                        cmd2_vld  = 1'b1;
                    end else begin
                        cmd1.skip = n_skip;
                        cmd1.bank = r_bank;
                        cmd1.eop  = 1'b1;
                        cmd1_vld  = 1'b1;
                    end
                    n_skip = 8'd0;
                end
            end else begin
                if ((lit_new >= MaxRun) || i_in_data.last_pixel) begin
                    cmd1.skip   = r_skip;
                    cmd1.lit    = lit_new;
                    cmd1.bank   = r_bank;
                    cmd1.eop    = i_in_data.last_pixel;
                    cmd1_vld    = 1'b1;
                    n_bank      = ~r_bank;
                    n_skip      = 8'd0;
                    n_lit       = '0;
                    n_lit_phase = 1'b0;
                end else begin
                    n_lit       = lit_new;
                    n_lit_phase = 1'b1;
                end
            end
        end
    end

    // queue push, second record is held pending until the queue has room; bank busy flags
    always_comb begin
        o_push     = 1'b0;
        o_push_cmd = cmd1;
        n_pend     = r_pend;
        n_pend_cmd = r_pend_cmd;
        if (r_pend) begin
            o_push_cmd = r_pend_cmd;
            if (!i_fifo_full) begin
                o_push = 1'b1;
                n_pend = 1'b0;
            end
        end else if (cmd1_vld) begin
            o_push     = 1'b1;
            n_pend     = cmd2_vld;
            n_pend_cmd = cmd2;
        end
        n_busy = r_busy;
        if (i_free.vld) begin
            n_busy[i_free.bank] = 1'b0;
        end
        if (o_push && (o_push_cmd.lit != '0)) begin
            n_busy[o_push_cmd.bank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit_phase <= 1'b0;
            r_skip      <= 8'd0;
            r_lit       <= '0;
            r_bank      <= 1'b0;
            r_busy      <= 2'b00;
            r_pend      <= 1'b0;
        end else begin
            r_lit_phase <= n_lit_phase;
            r_skip      <= n_skip;
            r_lit       <= n_lit;
            r_bank      <= n_bank;
            r_busy      <= n_busy;
            r_pend      <= n_pend;
        end
        r_pend_cmd <= n_pend_cmd;
    end

    `SSLRE_ASSERT(a_no_write_busy, i_clk, i_rst_n, o_wr_en |-> !r_busy[r_bank])
    `SSLRE_ASSERT(a_free_was_busy, i_clk, i_rst_n, i_free.vld |-> r_busy[i_free.bank])
    `SSLRE_ASSERT(a_no_double_busy, i_clk, i_rst_n, (o_push && (o_push_cmd.lit != '0)) |-> !r_busy[o_push_cmd.bank])

endmodule

@@ sv/sslre_fifo.sv @@
// short record queue between front and back end
// depends on sslre_pkg
module sslre_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sslre_pkg::t_cmd i_push_data,
    output logic            o_full,
    input  logic            i_pop,
    output sslre_pkg::t_cmd o_pop_data,
    output logic            o_empty
);

    localparam logic [sslre_pkg::CMD_AW:0] Depth = (sslre_pkg::CMD_AW + 1)'(sslre_pkg::CMD_DEPTH);

    sslre_pkg::t_cmd                r_mem [sslre_pkg::CMD_DEPTH];
    logic [sslre_pkg::CMD_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [sslre_pkg::CMD_AW:0]     r_count, n_count;

    assign o_full     = (r_count == Depth);
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

@@ sv/sslre_back.sv @@
// back end: writes each record byte by byte into 64-bit words, pads the picture end
// depends on sslre_pkg and the assertion header
`include "sprite_skip_literal_rle_encoder_assert.svh"

module sslre_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    output logic                         o_pop,
    input  sslre_pkg::t_cmd              i_cmd,
    output logic [sslre_pkg::RAM_AW-1:0] o_rd_addr,
    input  logic [7:0]                   i_rd_data,
    output sslre_pkg::t_bank_free        o_free,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output sslre_pkg::t_word_out         o_out_data
);

    sslre_pkg::t_back_state        r_state, n_state;
    sslre_pkg::t_cmd               r_cmd, n_cmd;
    logic [sslre_pkg::LIT_AW-1:0]  r_idx, n_idx;
    logic [55:0]                   r_pack, n_pack;
    logic [2:0]                    r_fill, n_fill;
    logic                          r_out_valid, n_out_valid;
    sslre_pkg::t_word_out          r_out, n_out;

    logic       out_free, step, last_of_rec, tail, final_byte, emit;
    logic [3:0] fill_next;
    logic [7:0] cur_byte;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign step        = (r_state != sslre_pkg::BK_IDLE) && out_free;
    assign last_of_rec = ((r_state == sslre_pkg::BK_COUNT) && (r_cmd.lit == '0))
                      || ((r_state == sslre_pkg::BK_DATA) && (r_idx == r_cmd.lit - 1'b1));
    assign tail        = last_of_rec || (r_state == sslre_pkg::BK_PAD);
    assign fill_next   = {1'b0, r_fill} + 4'd1;
    // picture ends once the stream length reaches a multiple of four bytes
    assign final_byte  = r_cmd.eop && tail && (fill_next[1:0] == 2'b00);
    assign emit        = step && ((r_fill == 3'd7) || final_byte);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sslre_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    n_state = sslre_pkg::BK_SKIP;
                end
            end
            sslre_pkg::BK_SKIP: begin
                if (step) begin
                    n_state = sslre_pkg::BK_COUNT;
                end
            end
            sslre_pkg::BK_COUNT, sslre_pkg::BK_DATA, sslre_pkg::BK_PAD: begin
                if (step) begin
                    if (tail) begin
                        if (!r_cmd.eop || final_byte) begin
                            n_state = sslre_pkg::BK_IDLE;
                        end else begin
                            n_state = sslre_pkg::BK_PAD;
                        end
                    end else begin
                        n_state = sslre_pkg::BK_DATA;
                    end
                end
            end
            default: n_state = sslre_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop = (r_state == sslre_pkg::BK_IDLE) && !i_empty;
        n_cmd = o_pop ? i_cmd : r_cmd;

        n_idx = r_idx;
        if (step && (r_state == sslre_pkg::BK_COUNT)) begin
            n_idx = '0;
        end else if (step && (r_state == sslre_pkg::BK_DATA)) begin
            n_idx = r_idx + 1'b1;
        end
        // read one ahead so the registered data matches r_idx
        o_rd_addr = {r_cmd.bank, n_idx};

        unique case (r_state)
            sslre_pkg::BK_SKIP:  cur_byte = r_cmd.skip;
            sslre_pkg::BK_COUNT: cur_byte = r_cmd.lit;
            sslre_pkg::BK_DATA:  cur_byte = i_rd_data;
            default:             cur_byte = 8'd0;
        endcase

        n_pack = r_pack;
        n_fill = r_fill;
        if (step) begin
            n_pack = {r_pack[47:0], cur_byte};
            n_fill = ((r_fill == 3'd7) || final_byte) ? 3'd0 : fill_next[2:0];
        end

        n_out = r_out;
        if (r_fill == 3'd7) begin
            n_out.packed_bytes   = {r_pack, cur_byte};
            n_out.valid_bytes    = sslre_pkg::FULL_BYTES;
            n_out.end_of_picture = final_byte;
        end else begin
            n_out.packed_bytes   = {r_pack[23:0], cur_byte, 32'd0};
            n_out.valid_bytes    = sslre_pkg::HALF_BYTES;
            n_out.end_of_picture = 1'b1;
        end
        if (!emit) begin
            n_out = r_out;
        end

        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end

        o_free.vld  = step && (r_state == sslre_pkg::BK_DATA) && last_of_rec;
        o_free.bank = r_cmd.bank;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sslre_pkg::BK_IDLE;
            r_fill      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_cmd  <= n_cmd;
        r_idx  <= n_idx;
        r_pack <= n_pack;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SSLRE_ASSERT(a_pad_needs_eop, i_clk, i_rst_n, (r_state == sslre_pkg::BK_PAD) |-> r_cmd.eop)
    `SSLRE_ASSERT(a_free_from_data, i_clk, i_rst_n, o_free.vld |-> ((r_state == sslre_pkg::BK_DATA) && (r_cmd.lit != '0)))
    `SSLRE_ASSERT(a_short_only_at_end, i_clk, i_rst_n, (r_out_valid && (r_out.valid_bytes != sslre_pkg::FULL_BYTES)) |-> r_out.end_of_picture)

endmodule

@@ sv/sprite_skip_literal_rle_encoder.sv @@
// Skip/literal run-length encoder for 8-bit palette pixels.
// Input channel: one pixel per item with last_pixel on the final pixel of a picture.
// Output channel: 64-bit words, first encoded byte in bits 63..56; valid_bytes is 8,
// or 4 on a short final word; end_of_picture marks the last word of a picture.
// Each record is a skip count, a literal count and the literal bytes, counts capped
// at MAX_RUN. The front end accepts one pixel per cycle; it stalls while a second
// record from a pixel that closed two records at once waits for the queue, while the
// two-record queue is full or while its literal bank is still being read out. The
// back end moves one byte per cycle while its output word is not stalled, and
// returns to its idle state between records to take the next one from the queue.
// Literals sit in a two-bank ram, so one record can be collected while the previous
// one is read out.
// Reset is synchronous and clears all run counters, the queue and the output valid flag.
// A stalled output word holds; the back end then stops, the queue fills and the
// input stalls in turn. No item is dropped.
// depends on sslre_pkg and the front, queue, ram and back modules
module sprite_skip_literal_rle_encoder #(
    parameter int MAX_RUN = 255
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sslre_pkg::t_pixel_in i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sslre_pkg::t_word_out o_out_data
);

    logic                          fifo_full, fifo_empty, push, pop;
    sslre_pkg::t_cmd               push_cmd, pop_cmd;
    logic                          wr_en;
    logic [sslre_pkg::RAM_AW-1:0]  wr_addr, rd_addr;
    logic [7:0]                    wr_data, rd_data;
    sslre_pkg::t_bank_free         bank_free;

    sslre_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_fifo_full (fifo_full),
        .o_push      (push),
        .o_push_cmd  (push_cmd),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .i_free      (bank_free)
    );

    sslre_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_cmd),
        .o_full      (fifo_full),
        .i_pop       (pop),
        .o_pop_data  (pop_cmd),
        .o_empty     (fifo_empty)
    );

    sslre_ram #(
        .WIDTH (8),
        .DEPTH (sslre_pkg::RAM_DEPTH)
    ) u_lit_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sslre_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (fifo_empty),
        .o_pop       (pop),
        .i_cmd       (pop_cmd),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_free      (bank_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
